// ===== sv/rgb_led_level_and_color_cycle_top_defines.svh =====
// assertion macros shared by the checker
`ifndef RGB_LED_LEVEL_AND_COLOR_CYCLE_TOP_DEFINES_SVH
`define RGB_LED_LEVEL_AND_COLOR_CYCLE_TOP_DEFINES_SVH

// checked on every clock edge outside reset
`define RLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define RLC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/rlc_pkg.sv =====
package rlc_pkg;

   // command codes
   localparam logic [2:0] CMD_SET      = 3'd0;
   localparam logic [2:0] CMD_TOGGLE   = 3'd1;
   localparam logic [2:0] CMD_INC      = 3'd2;
   localparam logic [2:0] CMD_DEC      = 3'd3;
   localparam logic [2:0] CMD_ALL_FULL = 3'd4;
   localparam logic [2:0] CMD_ALL_MEMO = 3'd5;
   localparam logic [2:0] CMD_PERIOD   = 3'd6;
   localparam logic [2:0] CMD_TICK     = 3'd7;

   localparam int NUM_CHANNELS = 3;

   localparam logic [3:0] LEVEL_STEPS = 4'd14;
   localparam logic [3:0] FULL_LEVEL  = 4'd15;
   localparam logic [3:0] MAX_PERIOD  = 4'd10;
   localparam logic [7:0] FULL_DUTY   = 8'd255;

   localparam int WAVE_LEN = 171;
   localparam int ROM_SIZE = 171;

   // rom read phase of red, green, blue
   localparam logic [7:0] PHASE [NUM_CHANNELS] = '{8'd0, 8'd85, 8'd170};

   localparam logic [7:0] LOG_DUTY [14] = '{
      8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd10, 8'd16, 8'd26, 8'd40,
      8'd64, 8'd102, 8'd161, 8'd255
   };

   localparam logic [7:0] SINE_ROM [ROM_SIZE] = '{
      8'd0,   8'd5,   8'd9,   8'd14,  8'd19,  8'd24,  8'd28,  8'd33,  8'd38,  8'd42,
      8'd47,  8'd51,  8'd56,  8'd61,  8'd65,  8'd70,  8'd74,  8'd79,  8'd83,  8'd88,
      8'd92,  8'd96,  8'd101, 8'd105, 8'd109, 8'd114, 8'd118, 8'd122, 8'd126, 8'd130,
      8'd134, 8'd138, 8'd142, 8'd146, 8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd168,
      8'd172, 8'd175, 8'd179, 8'd182, 8'd185, 8'd188, 8'd192, 8'd195, 8'd198, 8'd201,
      8'd203, 8'd206, 8'd209, 8'd212, 8'd214, 8'd217, 8'd219, 8'd222, 8'd224, 8'd226,
      8'd228, 8'd230, 8'd232, 8'd234, 8'd236, 8'd238, 8'd239, 8'd241, 8'd243, 8'd244,
      8'd245, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd251, 8'd252, 8'd253, 8'd253,
      8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254,
      8'd254, 8'd253, 8'd253, 8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
      8'd245, 8'd244, 8'd243, 8'd241, 8'd239, 8'd238, 8'd236, 8'd234, 8'd232, 8'd230,
      8'd228, 8'd226, 8'd224, 8'd222, 8'd219, 8'd217, 8'd214, 8'd212, 8'd209, 8'd206,
      8'd203, 8'd201, 8'd198, 8'd195, 8'd192, 8'd188, 8'd185, 8'd182, 8'd179, 8'd175,
      8'd172, 8'd168, 8'd165, 8'd161, 8'd157, 8'd154, 8'd150, 8'd146, 8'd142, 8'd138,
      8'd134, 8'd130, 8'd126, 8'd122, 8'd118, 8'd114, 8'd109, 8'd105, 8'd101, 8'd96,
      8'd92,  8'd88,  8'd83,  8'd79,  8'd74,  8'd70,  8'd65,  8'd61,  8'd56,  8'd51,
      8'd47,  8'd42,  8'd38,  8'd33,  8'd28,  8'd24,  8'd19,  8'd14,  8'd9,   8'd5,
      8'd0
   };

   typedef struct packed {
      logic [2:0] command;
      logic [1:0] channel;
      logic [7:0] value;
   } cmd_type;

   typedef struct packed {
      logic [7:0] duty_red;
      logic [7:0] duty_green;
      logic [7:0] duty_blue;
      logic       cycling_on;
   } result_type;

   // duty driven for a channel level
   function automatic logic [7:0] level_duty(input logic [3:0] lvl);
      logic [7:0] d;
      if (lvl == 4'd0) begin
         d = 8'd0;
      end else if (lvl > LEVEL_STEPS) begin
         d = FULL_DUTY;
      end else begin
         d = LOG_DUTY[lvl - 4'd1];
      end
      return d;
   endfunction

   // half-sine lookup, zero past the end of the wave
   function automatic logic [7:0] sine_duty(input logic [7:0] idx);
      logic [7:0] d;
      if (int'(idx) < WAVE_LEN && int'(idx) < ROM_SIZE) begin
         d = SINE_ROM[idx];
      end else begin
         d = 8'd0;
      end
      return d;
   endfunction

endpackage

// ===== sv/rlc_in_stage.sv =====
module rlc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_command,
   input  logic [1:0]        req_channel,
   input  logic [7:0]        req_value,
   input  logic              advance,
   output logic              cmd_valid,
   output rlc_pkg::cmd_type  cmd
);

   logic             valid_ff, valid_in;
   rlc_pkg::cmd_type cmd_ff, cmd_in;
   logic             take;

   // slot frees when its command moves on in the same cycle
   assign req_ready = !valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (take) begin
         valid_in       = 1'b1;
         cmd_in.command = req_command;
         cmd_in.channel = req_channel;
         cmd_in.value   = req_value;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

endmodule

// ===== sv/rlc_core.sv =====
module rlc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  rlc_pkg::cmd_type    cmd,
   output rlc_pkg::result_type result
);

   logic [3:0] level_ff [rlc_pkg::NUM_CHANNELS];
   logic [3:0] level_in [rlc_pkg::NUM_CHANNELS];
   logic [3:0] memo_ff  [rlc_pkg::NUM_CHANNELS];
   logic [3:0] memo_in  [rlc_pkg::NUM_CHANNELS];
   logic [7:0] duty_ff  [rlc_pkg::NUM_CHANNELS];
   logic [7:0] duty_in  [rlc_pkg::NUM_CHANNELS];
   logic [3:0] period_ff, period_in;
   logic [3:0] countdown_ff, countdown_in;
   logic [7:0] wave_pos_ff, wave_pos_in;

   logic [rlc_pkg::NUM_CHANNELS-1:0] changed;
   logic       any_level, any_memo, chan_cmd, tick_run, reload;
   logic       sel, want;
   logic [3:0] cur, nv;

   always_comb begin
      any_level = 1'b0;
      any_memo  = 1'b0;
      for (int c = 0; c < rlc_pkg::NUM_CHANNELS; c++) begin
         any_level = any_level || (level_ff[c] != 4'd0);
         any_memo  = any_memo  || (memo_ff[c] != 4'd0);
      end

      chan_cmd = (cmd.command == rlc_pkg::CMD_SET || cmd.command == rlc_pkg::CMD_TOGGLE ||
                  cmd.command == rlc_pkg::CMD_INC || cmd.command == rlc_pkg::CMD_DEC);
      tick_run = (cmd.command == rlc_pkg::CMD_TICK) && (period_ff != 4'd0);
      reload   = tick_run && (countdown_ff == 4'd0);

      sel  = 1'b0;
      want = 1'b0;
      cur  = 4'd0;
      nv   = 4'd0;
      for (int c = 0; c < rlc_pkg::NUM_CHANNELS; c++) begin
         sel        = chan_cmd && (cmd.channel == 2'(c));
         cur        = level_ff[c];
         nv         = cur;
         want       = 1'b0;
         memo_in[c] = memo_ff[c];
         case (cmd.command)
            rlc_pkg::CMD_SET: begin
               want = sel;
               nv   = (cmd.value > 8'(rlc_pkg::LEVEL_STEPS)) ? rlc_pkg::FULL_LEVEL
                                                            : cmd.value[3:0];
            end
            rlc_pkg::CMD_TOGGLE: begin
               want = sel;
               if (cur != 4'd0) begin
                  nv = 4'd0;
                  if (sel) begin
                     memo_in[c] = cur;
                  end
               end else if (memo_ff[c] != 4'd0) begin
                  nv = memo_ff[c];
               end else begin
                  nv = rlc_pkg::LEVEL_STEPS;
               end
            end
            rlc_pkg::CMD_INC: begin
               want = sel;
               if (cur == rlc_pkg::LEVEL_STEPS) begin
                  nv = 4'd0;
               end else if (cur > rlc_pkg::LEVEL_STEPS) begin
                  nv = rlc_pkg::FULL_LEVEL;
               end else begin
                  nv = cur + 4'd1;
               end
               if (sel) begin
                  memo_in[c] = nv;
               end
            end
            rlc_pkg::CMD_DEC: begin
               want = sel;
               if (cur == 4'd0 || cur > rlc_pkg::LEVEL_STEPS) begin
                  nv = rlc_pkg::LEVEL_STEPS;
               end else begin
                  nv = cur - 4'd1;
               end
               if (sel) begin
                  memo_in[c] = nv;
               end
            end
            rlc_pkg::CMD_ALL_FULL: begin
               want = 1'b1;
               nv   = any_level ? 4'd0 : rlc_pkg::LEVEL_STEPS;
            end
            rlc_pkg::CMD_ALL_MEMO: begin
               want = 1'b1;
               if (any_level) begin
                  nv = 4'd0;
               end else if (any_memo) begin
                  nv = memo_ff[c];
               end else begin
                  nv = rlc_pkg::LEVEL_STEPS;
               end
            end
            default: begin
               want = 1'b0;
            end
         endcase

         changed[c]  = want && (nv != cur);
         level_in[c] = changed[c] ? nv : cur;
         if (changed[c]) begin
            duty_in[c] = rlc_pkg::level_duty(nv);
         end else if (reload) begin
            duty_in[c] = rlc_pkg::sine_duty(wave_pos_ff + rlc_pkg::PHASE[c]);
         end else begin
            duty_in[c] = duty_ff[c];
         end
      end

      // any real level change stops cycling
      if (|changed) begin
         period_in = 4'd0;
      end else if (cmd.command == rlc_pkg::CMD_PERIOD) begin
         period_in = (cmd.value > 8'(rlc_pkg::MAX_PERIOD)) ? rlc_pkg::MAX_PERIOD
                                                          : cmd.value[3:0];
      end else begin
         period_in = period_ff;
      end

      countdown_in = countdown_ff;
      wave_pos_in  = wave_pos_ff;
      if (reload) begin
         countdown_in = period_ff - 4'd1;
         wave_pos_in  = wave_pos_ff + 8'd1;
      end else if (tick_run) begin
         countdown_in = countdown_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < rlc_pkg::NUM_CHANNELS; c++) begin
            level_ff[c] <= 4'd0;
            memo_ff[c]  <= 4'd0;
            duty_ff[c]  <= 8'd0;
         end
         period_ff    <= 4'd0;
         countdown_ff <= 4'd0;
         wave_pos_ff  <= 8'd0;
      end else if (fire) begin
         for (int c = 0; c < rlc_pkg::NUM_CHANNELS; c++) begin
            level_ff[c] <= level_in[c];
            memo_ff[c]  <= memo_in[c];
            duty_ff[c]  <= duty_in[c];
         end
         period_ff    <= period_in;
         countdown_ff <= countdown_in;
         wave_pos_ff  <= wave_pos_in;
      end
   end

   assign result.duty_red   = duty_in[0];
   assign result.duty_green = duty_in[1];
   assign result.duty_blue  = duty_in[2];
   assign result.cycling_on = (period_in != 4'd0);

endmodule

// ===== sv/rlc_out_stage.sv =====
module rlc_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  rlc_pkg::result_type result,
   output logic                can_load,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_duty_red,
   output logic [7:0]          rsp_duty_green,
   output logic [7:0]          rsp_duty_blue,
   output logic                rsp_cycling_on
);

   logic                valid_ff, valid_in;
   rlc_pkg::result_type result_ff, result_in;

   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_duty_red   = result_ff.duty_red;
   assign rsp_duty_green = result_ff.duty_green;
   assign rsp_duty_blue  = result_ff.duty_blue;
   assign rsp_cycling_on = result_ff.cycling_on;

endmodule

// ===== sv/rgb_led_level_and_color_cycle_top.sv =====
// an accepted command is registered, then its result beat is registered for the rsp side
// throughput: one command per cycle, limited only by the result side taking beats
// the command register and the result register each free up in the cycle they drain
// reset: synchronous, active high; clears all levels, memos, duties and the cycle state
// and empties both registers, so no result beat is shown until a command arrives
module rgb_led_level_and_color_cycle_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_command,
   input  logic [1:0] req_channel,
   input  logic [7:0] req_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_duty_red,
   output logic [7:0] rsp_duty_green,
   output logic [7:0] rsp_duty_blue,
   output logic       rsp_cycling_on
);

   // registered command waiting for the state update
   logic                cmd_valid;
   rlc_pkg::cmd_type    cmd;

   // next state as seen by the result register
   rlc_pkg::result_type result;

   // handshake between the two registers
   logic                can_load;
   logic                fire;

   // a command executes when the result register has room for its beat
   assign fire = cmd_valid && can_load;

   // command register: takes a new beat while a result beat is stalled only if it is empty
   rlc_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_channel (req_channel),
      .req_value   (req_value),
      .advance     (fire),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd)
   );

   // levels, memos, duties and the color-cycle state; updates on fire
   rlc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .cmd    (cmd),
      .result (result)
   );

   // result register feeding the rsp channel
   rlc_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (fire),
      .result         (result),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_duty_red   (rsp_duty_red),
      .rsp_duty_green (rsp_duty_green),
      .rsp_duty_blue  (rsp_duty_blue),
      .rsp_cycling_on (rsp_cycling_on)
   );

endmodule

// ===== sv/rlc_chk.sv =====
`include "rgb_led_level_and_color_cycle_top_defines.svh"

module rlc_chk (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [2:0] req_command,
   input logic [1:0] req_channel,
   input logic [7:0] req_value,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_duty_red,
   input logic [7:0] rsp_duty_green,
   input logic [7:0] rsp_duty_blue,
   input logic       rsp_cycling_on
);

   logic        req_stall;
   logic        rsp_stall;
   logic [12:0] req_payload;
   logic [24:0] rsp_payload;

   assign req_stall   = req_valid && !req_ready;
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign req_payload = {req_command, req_channel, req_value};
   assign rsp_payload = {rsp_duty_red, rsp_duty_green, rsp_duty_blue, rsp_cycling_on};

   // no result beat right after reset
   `RLC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result beat shown after reset")

   // an empty result side never blocks a command
   `RLC_ASSERT(a_ready_when_empty, !rsp_valid |-> req_ready, "command stalled, nothing pending")

   // a stalled command beat stays with its payload
   `RLC_ASSERT(a_req_hold, req_stall |=> req_valid && $stable(req_payload), "stalled command changed")

   // a stalled result beat stays
   `RLC_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid, "result beat dropped while stalled")

   // a stalled result beat keeps its payload
   `RLC_ASSERT(a_rsp_stable, rsp_stall |=> $stable(rsp_payload), "result payload changed")

endmodule

bind rgb_led_level_and_color_cycle_top rlc_chk u_chk (.*);

// ===== test/tb_rgb_led_level_and_color_cycle_top.sv =====
module tb_rgb_led_level_and_color_cycle_top;
   timeunit 1ns;
   timeprecision 1ps;

   // channel select codes, the last one selects nothing
   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;
   localparam logic [1:0] CH_NONE  = 2'd3;

   // command beats sent before the stimulus ends
   localparam int TARGET_COMMANDS = 2000;
   // cycles with no beat on either side before the run is called hung
   localparam int IDLE_LIMIT      = 2000;
   // margin to catch stray beats at the end
   localparam int SETTLE_CYCLES   = 10;
   localparam int REPORT_LIMIT    = 10;

   // ------------------------------------------------------------------
   // duty predictor and result store
   // ------------------------------------------------------------------
   class duty_scoreboard;
      logic [3:0] lvl [rlc_pkg::NUM_CHANNELS];
      logic [3:0] memo [rlc_pkg::NUM_CHANNELS];
      logic [7:0] duty [rlc_pkg::NUM_CHANNELS];
      logic [3:0] period;
      logic [3:0] countdown;
      logic [7:0] wave_pos;
      rlc_pkg::result_type expected_q[$];
      int mismatches;
      int beats_checked;
      int sine_steps;
      int wave_wraps;
      int cycle_stops;

      function new();
         for (int i = 0; i < rlc_pkg::NUM_CHANNELS; i++) begin
            lvl[i] = '0;
            memo[i] = '0;
            duty[i] = '0;
         end
         period = '0;
         countdown = '0;
         wave_pos = '0;
         mismatches = 0;
         beats_checked = 0;
         sine_steps = 0;
         wave_wraps = 0;
         cycle_stops = 0;
      endfunction

      // a real level change kills cycling and redrives that channel only
      function void put_level(int ch, logic [3:0] v);
         if (v == lvl[ch]) return;
         if (period != 0) cycle_stops++;
         period = '0;
         lvl[ch] = v;
         if (v == 4'd0) begin
            duty[ch] = 8'd0;
         end else if (v > rlc_pkg::LEVEL_STEPS) begin
            duty[ch] = rlc_pkg::FULL_DUTY;
         end else begin
            duty[ch] = rlc_pkg::LOG_DUTY[v - 4'd1];
         end
      endfunction

      // half-sine lookup with the 8-bit wrap of the read position
      function logic [7:0] wave_at(logic [7:0] phase);
         logic [7:0] idx;
         idx = wave_pos + phase;
         if (int'(idx) >= rlc_pkg::WAVE_LEN) return 8'd0;
         return rlc_pkg::SINE_ROM[idx];
      endfunction

      function bit any_level();
         return (lvl[0] != 0) || (lvl[1] != 0) || (lvl[2] != 0);
      endfunction

      // predicts one accepted command, returns 0 when the block ignores it
      function bit note_cmd(rlc_pkg::cmd_type c);
         rlc_pkg::result_type want;
         logic [3:0] cur;
         logic [3:0] nv;
         int ch;
         bit live;
         live = 1'b1;
         ch = int'(c.channel);
         case (c.command)
            rlc_pkg::CMD_SET, rlc_pkg::CMD_TOGGLE, rlc_pkg::CMD_INC, rlc_pkg::CMD_DEC: begin
               if (c.channel == CH_NONE) begin
                  live = 1'b0;
               end else begin
                  cur = lvl[ch];
                  if (c.command == rlc_pkg::CMD_SET) begin
                     put_level(ch, (c.value > rlc_pkg::LEVEL_STEPS) ? rlc_pkg::FULL_LEVEL
                                                                    : c.value[3:0]);
                  end else if (c.command == rlc_pkg::CMD_TOGGLE) begin
                     if (cur != 0) begin
                        memo[ch] = cur;
                        nv = 4'd0;
                     end else if (memo[ch] != 0) begin
                        nv = memo[ch];
                     end else begin
                        nv = rlc_pkg::LEVEL_STEPS;
                     end
                     put_level(ch, nv);
                  end else if (c.command == rlc_pkg::CMD_INC) begin
                     if (cur == rlc_pkg::LEVEL_STEPS) nv = 4'd0;
                     else if (cur > rlc_pkg::LEVEL_STEPS) nv = rlc_pkg::FULL_LEVEL;
                     else nv = cur + 4'd1;
                     put_level(ch, nv);
                     memo[ch] = lvl[ch];
                  end else begin
                     if (cur == 0 || cur > rlc_pkg::LEVEL_STEPS) nv = rlc_pkg::LEVEL_STEPS;
                     else nv = cur - 4'd1;
                     put_level(ch, nv);
                     memo[ch] = lvl[ch];
                  end
               end
            end
            rlc_pkg::CMD_ALL_FULL: begin
               nv = any_level() ? 4'd0 : rlc_pkg::LEVEL_STEPS;
               for (int i = 0; i < rlc_pkg::NUM_CHANNELS; i++) put_level(i, nv);
            end
            rlc_pkg::CMD_ALL_MEMO: begin
               if (any_level()) begin
                  for (int i = 0; i < rlc_pkg::NUM_CHANNELS; i++) put_level(i, 4'd0);
               end else if (memo[0] != 0 || memo[1] != 0 || memo[2] != 0) begin
                  for (int i = 0; i < rlc_pkg::NUM_CHANNELS; i++) put_level(i, memo[i]);
               end else begin
                  for (int i = 0; i < rlc_pkg::NUM_CHANNELS; i++) begin
                     put_level(i, rlc_pkg::LEVEL_STEPS);
                  end
               end
            end
            rlc_pkg::CMD_PERIOD: begin
               period = (c.value <= rlc_pkg::MAX_PERIOD) ? c.value[3:0] : rlc_pkg::MAX_PERIOD;
            end
            default: begin
               if (period == 0) begin
                  live = 1'b0;
               end else begin
                  if (countdown == 0) begin
                     countdown = period;
                     for (int i = 0; i < rlc_pkg::NUM_CHANNELS; i++) begin
                        duty[i] = wave_at(rlc_pkg::PHASE[i]);
                     end
                     if (wave_pos == 8'hFF) wave_wraps++;
                     wave_pos = wave_pos + 8'd1;
                     sine_steps++;
                  end
                  countdown = countdown - 4'd1;
               end
            end
         endcase
         want.duty_red = duty[0];
         want.duty_green = duty[1];
         want.duty_blue = duty[2];
         want.cycling_on = (period != 0);
         expected_q.push_back(want);
         return live;
      endfunction

      function void report(string what, rlc_pkg::result_type want,
                           rlc_pkg::result_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display({"[%0t] %s: expected r=%0d g=%0d b=%0d cyc=%0b,",
                      " got r=%0d g=%0d b=%0d cyc=%0b"},
                     $realtime, what, want.duty_red, want.duty_green, want.duty_blue,
                     want.cycling_on, got.duty_red, got.duty_green, got.duty_blue,
                     got.cycling_on);
         end
      endfunction

      // compares one result beat with the oldest expectation
      function void check_result(rlc_pkg::result_type got);
         rlc_pkg::result_type want;
         if (expected_q.size() == 0) begin
            want = '0;
            report("result beat with nothing expected", want, got);
            return;
         end
         want = expected_q.pop_front();
         beats_checked++;
         if (got.duty_red !== want.duty_red) report("red duty mismatch", want, got);
         if (got.duty_green !== want.duty_green) report("green duty mismatch", want, got);
         if (got.duty_blue !== want.duty_blue) report("blue duty mismatch", want, got);
         if (got.cycling_on !== want.cycling_on) report("cycling flag mismatch", want, got);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   // ------------------------------------------------------------------
   // signals and block under test
   // ------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_command = '0;
   logic [1:0] req_channel = '0;
   logic [7:0] req_value = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_duty_red;
   logic [7:0] rsp_duty_green;
   logic [7:0] rsp_duty_blue;
   logic       rsp_cycling_on;

   duty_scoreboard      board;
   rlc_pkg::result_type rsp_beat;

   int burst_left = 0;
   int cmds_sent = 0;
   int cmds_live = 0;
   int idle_cycles = 0;

   rgb_led_level_and_color_cycle_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_channel    (req_channel),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_duty_red   (rsp_duty_red),
      .rsp_duty_green (rsp_duty_green),
      .rsp_duty_blue  (rsp_duty_blue),
      .rsp_cycling_on (rsp_cycling_on)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // result side: stall pattern switches at random among open, coin, sparse and periodic modes
   // ------------------------------------------------------------------
   typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;
   rx_mode_type rx_mode = RX_OPEN;
   int rx_left = 0;
   int rx_count = 0;

   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(30, 150);
      end
      rx_left--;
      rx_count++;
      case (rx_mode)
         RX_OPEN:   rsp_ready <= 1'b1;
         RX_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:   rsp_ready <= (rx_count % 5 == 0);
      endcase
   end

   // every result beat taken is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beat.duty_red = rsp_duty_red;
         rsp_beat.duty_green = rsp_duty_green;
         rsp_beat.duty_blue = rsp_duty_blue;
         rsp_beat.cycling_on = rsp_cycling_on;
         board.check_result(rsp_beat);
      end
   end

   // hang detection: no beat moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, board.pending());
            $display("Verification failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // command side
   // ------------------------------------------------------------------
   function automatic rlc_pkg::cmd_type make_cmd(logic [2:0] cmd, logic [1:0] ch,
                                                 logic [7:0] val);
      rlc_pkg::cmd_type c;
      c.command = cmd;
      c.channel = ch;
      c.value = val;
      return c;
   endfunction

   // one command beat; the sender runs in bursts with random gaps between
   task automatic send_cmd(input rlc_pkg::cmd_type c);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         // now and then a long burst with no idling at all
         burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= c.command;
      req_channel <= c.channel;
      req_value <= c.value;
      do @(posedge clock); while (!req_ready);
      cmds_sent++;
      if (board.note_cmd(c)) cmds_live++;
   endtask

   // loose command mix, the invalid channel now and then
   function automatic rlc_pkg::cmd_type random_cmd();
      rlc_pkg::cmd_type c;
      int pick;
      pick = $urandom_range(0, 99);
      c.channel = ($urandom_range(0, 9) == 0) ? CH_NONE : 2'($urandom_range(0, 2));
      c.value = 8'($urandom_range(0, 255));
      if (pick < 15) begin
         c.command = rlc_pkg::CMD_SET;
         if ($urandom_range(0, 1) == 0) c.value = 8'($urandom_range(0, 15));
      end else if (pick < 30) begin
         c.command = rlc_pkg::CMD_TOGGLE;
      end else if (pick < 42) begin
         c.command = rlc_pkg::CMD_INC;
      end else if (pick < 54) begin
         c.command = rlc_pkg::CMD_DEC;
      end else if (pick < 60) begin
         c.command = rlc_pkg::CMD_ALL_FULL;
      end else if (pick < 66) begin
         c.command = rlc_pkg::CMD_ALL_MEMO;
      end else if (pick < 72) begin
         c.command = rlc_pkg::CMD_PERIOD;
      end else begin
         c.command = rlc_pkg::CMD_TICK;
      end
      return c;
   endfunction

   // period beat followed by a run of ticks; short periods walk the wave fast
   task automatic run_cycle_burst();
      int pick;
      int ticks;
      logic [7:0] per;
      pick = $urandom_range(0, 9);
      if (pick < 6) per = 8'd1;
      else if (pick < 8) per = 8'($urandom_range(2, 4));
      else per = 8'($urandom_range(0, 255));
      send_cmd(make_cmd(rlc_pkg::CMD_PERIOD, 2'($urandom_range(0, 3)), per));
      ticks = $urandom_range(20, 120);
      repeat (ticks) begin
         // rarely a stray command breaks the cycle mid-run
         if ($urandom_range(0, 39) == 0) begin
            send_cmd(random_cmd());
         end else begin
            send_cmd(make_cmd(rlc_pkg::CMD_TICK, 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255))));
         end
      end
   endtask

   initial begin
      rlc_pkg::cmd_type directed[$];
      board = new();

      // reset held high at the start, released on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corner cases
      directed.push_back(make_cmd(rlc_pkg::CMD_TICK, CH_RED, 8'd0));       // tick while idle
      directed.push_back(make_cmd(rlc_pkg::CMD_ALL_MEMO, CH_RED, 8'd0));   // dark, no memo: max
      directed.push_back(make_cmd(rlc_pkg::CMD_ALL_MEMO, CH_RED, 8'd0));   // lit: all off
      directed.push_back(make_cmd(rlc_pkg::CMD_TOGGLE, CH_RED, 8'd0));     // empty memo: max
      directed.push_back(make_cmd(rlc_pkg::CMD_TOGGLE, CH_RED, 8'd0));     // off, memo kept
      directed.push_back(make_cmd(rlc_pkg::CMD_TOGGLE, CH_RED, 8'd0));     // back to memo
      directed.push_back(make_cmd(rlc_pkg::CMD_SET, CH_GREEN, 8'hFF));     // saturates to full
      directed.push_back(make_cmd(rlc_pkg::CMD_INC, CH_GREEN, 8'h00));     // full stays full
      directed.push_back(make_cmd(rlc_pkg::CMD_DEC, CH_GREEN, 8'h00));     // full drops to max
      directed.push_back(make_cmd(rlc_pkg::CMD_INC, CH_GREEN, 8'h00));     // max wraps to off
      directed.push_back(make_cmd(rlc_pkg::CMD_DEC, CH_GREEN, 8'h00));     // off wraps to max
      directed.push_back(make_cmd(rlc_pkg::CMD_SET, CH_BLUE, 8'd1));
      directed.push_back(make_cmd(rlc_pkg::CMD_SET, CH_BLUE, 8'd1));       // same level
      directed.push_back(make_cmd(rlc_pkg::CMD_SET, CH_NONE, 8'd3));       // invalid channel
      directed.push_back(make_cmd(rlc_pkg::CMD_ALL_FULL, CH_NONE, 8'hAA)); // lit: all off
      directed.push_back(make_cmd(rlc_pkg::CMD_ALL_FULL, CH_RED, 8'h55));  // dark: all to max
      directed.push_back(make_cmd(rlc_pkg::CMD_PERIOD, CH_RED, 8'hFF));    // clamps period
      directed.push_back(make_cmd(rlc_pkg::CMD_TICK, CH_RED, 8'd0));
      directed.push_back(make_cmd(rlc_pkg::CMD_TICK, CH_BLUE, 8'd0));
      directed.push_back(make_cmd(rlc_pkg::CMD_PERIOD, CH_RED, 8'd0));     // cycling off
      directed.push_back(make_cmd(rlc_pkg::CMD_TICK, CH_RED, 8'd0));
      directed.push_back(make_cmd(rlc_pkg::CMD_PERIOD, CH_GREEN, 8'd1));
      directed.push_back(make_cmd(rlc_pkg::CMD_TICK, CH_RED, 8'd0));
      directed.push_back(make_cmd(rlc_pkg::CMD_SET, CH_RED, 8'd0));        // stops cycling
      directed.push_back(make_cmd(rlc_pkg::CMD_SET, CH_RED, 8'd16));       // past range, full
      foreach (directed[i]) send_cmd(directed[i]);

      // random part: mostly cycling runs and level commands
      while (cmds_sent < TARGET_COMMANDS) begin
         if ($urandom_range(0, 3) == 0) run_cycle_burst();
         else send_cmd(random_cmd());
      end

      // drain, then let stray beats show up
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("%0d command beats (%0d with effect), %0d result beats checked, %0d mismatches",
               cmds_sent, cmds_live, board.beats_checked, board.mismatches);
      $display("%0d sine steps, %0d wave wraps, %0d cycling runs stopped by level changes",
               board.sine_steps, board.wave_wraps, board.cycle_stops);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
